>>> src/mmfn_pkg.sv
`default_nettype none

package mmfn_pkg;

  // sizes
  localparam int MAX_FEATURES = 16;
  localparam int MAX_SAMPLES  = 4096;
  localparam int FEAT_W       = $clog2(MAX_FEATURES);
  localparam int ADDR_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int NF_W         = 5;
  localparam int DIV_W        = 16;
  localparam int Q_W          = DIV_W + 1;
  localparam int STEP_W       = $clog2(Q_W + 1);
  localparam int PC_W         = 4;

  // request kinds
  localparam logic [1:0] K_LOAD   = 2'd0;
  localparam logic [1:0] K_EMIT   = 2'd1;
  localparam logic [1:0] K_CLEAR  = 2'd2;
  localparam logic [1:0] K_UNUSED = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIV_LOAD,
    OP_DIV_EMIT,
    OP_DIV_STEP,
    OP_LOAD_WR,
    OP_SET_OVF,
    OP_FETCH,
    OP_RANGE,
    OP_DIV_NORM,
    OP_EMIT_WR,
    OP_EMPTY_WR,
    OP_CLEAR
  } op_t;

  // sequencer branch conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_DISPATCH,
    C_FULL,
    C_EMPTY,
    C_DIV_LOOP,
    C_OUT_WAIT
  } cond_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic fire;
  } ctl_t;

  typedef struct packed {
    logic div_last;
    logic load_full;
    logic emit_empty;
    logic out_busy;
  } stat_t;

  // program addresses
  localparam pc_t A_IDLE  = 4'd0;
  localparam pc_t A_LOAD  = 4'd1;
  localparam pc_t A_LDIV  = 4'd2;
  localparam pc_t A_LWR   = 4'd3;
  localparam pc_t A_OVF   = 4'd4;
  localparam pc_t A_EMIT  = 4'd5;
  localparam pc_t A_EDIV  = 4'd6;
  localparam pc_t A_FETCH = 4'd7;
  localparam pc_t A_RANGE = 4'd8;
  localparam pc_t A_NORM  = 4'd9;
  localparam pc_t A_NDIV  = 4'd10;
  localparam pc_t A_OUT   = 4'd11;
  localparam pc_t A_NONE  = 4'd12;
  localparam pc_t A_CLR   = 4'd13;

  // control store
  function automatic uword_t ucode_rom(pc_t a);
    uword_t w;
    unique case (a)
      A_IDLE:  w = '{op: OP_NOP,      cond: C_DISPATCH, target: A_IDLE};
      A_LOAD:  w = '{op: OP_DIV_LOAD, cond: C_FULL,     target: A_OVF};
      A_LDIV:  w = '{op: OP_DIV_STEP, cond: C_DIV_LOOP, target: A_IDLE};
      A_LWR:   w = '{op: OP_LOAD_WR,  cond: C_GOTO,     target: A_IDLE};
      A_OVF:   w = '{op: OP_SET_OVF,  cond: C_GOTO,     target: A_IDLE};
      A_EMIT:  w = '{op: OP_DIV_EMIT, cond: C_EMPTY,    target: A_NONE};
      A_EDIV:  w = '{op: OP_DIV_STEP, cond: C_DIV_LOOP, target: A_IDLE};
      A_FETCH: w = '{op: OP_FETCH,    cond: C_NEXT,     target: A_IDLE};
      A_RANGE: w = '{op: OP_RANGE,    cond: C_NEXT,     target: A_IDLE};
      A_NORM:  w = '{op: OP_DIV_NORM, cond: C_NEXT,     target: A_IDLE};
      A_NDIV:  w = '{op: OP_DIV_STEP, cond: C_DIV_LOOP, target: A_IDLE};
      A_OUT:   w = '{op: OP_EMIT_WR,  cond: C_OUT_WAIT, target: A_IDLE};
      A_NONE:  w = '{op: OP_EMPTY_WR, cond: C_OUT_WAIT, target: A_IDLE};
      A_CLR:   w = '{op: OP_CLEAR,    cond: C_GOTO,     target: A_IDLE};
      default: w = '{op: OP_NOP,      cond: C_GOTO,     target: A_IDLE};
    endcase
    return w;
  endfunction

  // entry point of each request kind
  function automatic pc_t dispatch(logic [1:0] kind);
    pc_t a;
    unique case (kind)
      K_LOAD:  a = A_LOAD;
      K_EMIT:  a = A_EMIT;
      K_CLEAR: a = A_CLR;
      default: a = A_IDLE;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> src/mmfn_if.sv
`default_nettype none

// request channel
interface mmfn_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] sample;
  logic [5:0]         class_id;

  modport source(output valid, kind, sample, class_id, input ready);
  modport sink(input valid, kind, sample, class_id, output ready);
endinterface

// result channel
interface mmfn_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] scaled;
  logic [5:0]         class_id_out;
  logic [3:0]         feature_index;
  logic [11:0]        record_index;
  logic               last;
  logic [1:0]         status;

  modport source(output valid, scaled, class_id_out, feature_index, record_index, last,
                 status, input ready);
  modport sink(input valid, scaled, class_id_out, feature_index, record_index, last,
               status, output ready);
endinterface

// configuration write channel
interface mmfn_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] num_features;

  modport source(output valid, num_features, input ready);
  modport sink(input valid, num_features, output ready);
endinterface

`default_nettype wire

>>> src/mmfn_div.sv
`default_nettype none

module mmfn_div import mmfn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              step,
  input  logic [STEP_W-1:0] steps,
  input  logic [DIV_W-1:0]  init_rem,
  input  logic [DIV_W-1:0]  init_num,
  input  logic [DIV_W-1:0]  divisor,
  output logic [Q_W-1:0]    quo,
  output logic [DIV_W-1:0]  rem,
  output logic              last
);

  logic [DIV_W-1:0]  num;
  logic [DIV_W-1:0]  dvs;
  logic [STEP_W-1:0] cnt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  assign trial = {rem, num[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});
  assign last  = (cnt == STEP_W'(1));

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (step) begin
      cnt <= cnt - STEP_W'(1);
    end
  end

  // partial remainder, numerator and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= init_rem;
      num <= init_num;
      quo <= '0;
      dvs <= divisor;
    end else if (step) begin
      rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      num <= {num[DIV_W-2:0], 1'b0};
      quo <= {quo[Q_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> src/mmfn_seq.sv
`default_nettype none

module mmfn_seq import mmfn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic [1:0] cmd_kind,
  input  stat_t      stat,
  output ctl_t       ctl,
  output logic       idle
);

  pc_t    pc;
  pc_t    pc_next;
  uword_t uw;

  assign uw   = ucode_rom(pc);
  assign idle = (pc == A_IDLE);

  // the output step only acts once the result register is free
  assign ctl.op   = uw.op;
  assign ctl.fire = !((uw.cond == C_OUT_WAIT) && stat.out_busy);

  // next step address
  always_comb begin
    pc_next = pc;
    unique case (uw.cond)
      C_NEXT:     pc_next = pc + pc_t'(1);
      C_GOTO:     pc_next = uw.target;
      C_DISPATCH: pc_next = cmd_valid ? dispatch(cmd_kind) : pc;
      C_FULL:     pc_next = stat.load_full ? uw.target : pc + pc_t'(1);
      C_EMPTY:    pc_next = stat.emit_empty ? uw.target : pc + pc_t'(1);
      C_DIV_LOOP: pc_next = stat.div_last ? pc + pc_t'(1) : pc;
      C_OUT_WAIT: pc_next = stat.out_busy ? pc : uw.target;
      default:    pc_next = A_IDLE;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

>>> src/mmfn_dp.sv
`default_nettype none

module mmfn_dp import mmfn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl,
  input  logic               accept,
  input  logic signed [15:0] cmd_sample,
  input  logic [5:0]         cmd_class_id,
  input  logic [NF_W-1:0]    nf,
  output stat_t              stat,
  mmfn_result_if.source      result
);

  // stores
  logic [15:0]        sample_store [MAX_SAMPLES];
  logic [5:0]         class_store  [MAX_SAMPLES];
  logic signed [15:0] fmin [MAX_FEATURES];
  logic signed [15:0] fmax [MAX_FEATURES];

  logic [CNT_W-1:0]        load_count;
  logic [CNT_W-1:0]        emit_count;
  logic                    ovf;
  logic [MAX_FEATURES-1:0] seen;

  logic signed [15:0] sample_in;
  logic [5:0]         class_in;
  logic [15:0]        x_rd;
  logic [5:0]         cls_rd;
  logic [FEAT_W-1:0]  f_reg;
  logic [ADDR_W-1:0]  rec_reg;
  logic [DIV_W-1:0]   d_reg;
  logic [DIV_W-1:0]   r_reg;
  logic               flat;

  logic               out_valid;
  logic signed [15:0] scaled_r;
  logic [5:0]         class_r;
  logic [3:0]         feat_r;
  logic [11:0]        rec_r;
  logic               last_r;
  logic [1:0]         status_r;

  logic               div_start;
  logic               div_step;
  logic [STEP_W-1:0]  div_steps;
  logic [DIV_W-1:0]   div_rem0;
  logic [DIV_W-1:0]   div_num0;
  logic [DIV_W-1:0]   div_dvs;
  logic [Q_W-1:0]     div_quo;
  logic [DIV_W-1:0]   div_rem;
  logic               div_last;

  logic               do_load;
  logic               do_fetch;
  logic               do_range;
  logic               do_emit;
  logic               do_empty;
  logic [FEAT_W-1:0]  feat;
  logic [ADDR_W-1:0]  rec;
  logic signed [15:0] lo;
  logic signed [15:0] hi;
  logic signed [16:0] dx;
  logic signed [16:0] rng;
  logic signed [16:0] dc;
  logic signed [15:0] scaled_calc;

  assign do_load  = ctl.fire && (ctl.op == OP_LOAD_WR);
  assign do_fetch = ctl.fire && (ctl.op == OP_FETCH);
  assign do_range = ctl.fire && (ctl.op == OP_RANGE);
  assign do_emit  = ctl.fire && (ctl.op == OP_EMIT_WR);
  assign do_empty = ctl.fire && (ctl.op == OP_EMPTY_WR);

  // position split: remainder is the feature, quotient the record
  assign feat = div_rem[FEAT_W-1:0];
  assign rec  = div_quo[ADDR_W-1:0];

  // divider setup per operation
  assign div_start = ctl.fire && ((ctl.op == OP_DIV_LOAD) || (ctl.op == OP_DIV_EMIT) ||
                                  (ctl.op == OP_DIV_NORM));
  assign div_step  = ctl.fire && (ctl.op == OP_DIV_STEP);

  always_comb begin
    div_rem0  = '0;
    div_num0  = '0;
    div_steps = STEP_W'(CNT_W);
    div_dvs   = {{(DIV_W-NF_W){1'b0}}, nf};
    unique case (ctl.op)
      OP_DIV_LOAD: div_num0 = {load_count, {(DIV_W-CNT_W){1'b0}}};
      OP_DIV_EMIT: div_num0 = {emit_count, {(DIV_W-CNT_W){1'b0}}};
      OP_DIV_NORM: begin
        // d is at most r, so start one bit in and take 17 quotient bits
        div_rem0  = {1'b0, d_reg[DIV_W-1:1]};
        div_num0  = {d_reg[0], {(DIV_W-1){1'b0}}};
        div_steps = STEP_W'(Q_W);
        div_dvs   = r_reg;
      end
      default: ;
    endcase
  end

  mmfn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .step     (div_step),
    .steps    (div_steps),
    .init_rem (div_rem0),
    .init_num (div_num0),
    .divisor  (div_dvs),
    .quo      (div_quo),
    .rem      (div_rem),
    .last     (div_last)
  );

  // request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_in <= cmd_sample;
      class_in  <= cmd_class_id;
    end
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (do_load) begin
      sample_store[load_count[ADDR_W-1:0]] <= sample_in;
    end
    if (do_fetch) begin
      x_rd <= sample_store[emit_count[ADDR_W-1:0]];
    end
  end

  // record class memory
  always_ff @(posedge clk) begin
    if (do_load && (feat == '0)) begin
      class_store[rec] <= class_in;
    end
    if (do_fetch) begin
      cls_rd <= class_store[rec];
    end
  end

  // running min and max per feature
  always_ff @(posedge clk) begin
    if (do_load) begin
      if (!seen[feat]) begin
        fmin[feat] <= sample_in;
        fmax[feat] <= sample_in;
      end else begin
        if (sample_in < fmin[feat]) fmin[feat] <= sample_in;
        if (sample_in > fmax[feat]) fmax[feat] <= sample_in;
      end
    end
  end

  // counters, overflow and feature valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      emit_count <= '0;
      ovf        <= 1'b0;
      seen       <= '0;
    end else if (ctl.fire) begin
      unique case (ctl.op)
        OP_LOAD_WR: begin
          load_count <= load_count + CNT_W'(1);
          seen[feat] <= 1'b1;
        end
        OP_SET_OVF: ovf <= 1'b1;
        OP_EMIT_WR: emit_count <= emit_count + CNT_W'(1);
        OP_CLEAR: begin
          load_count <= '0;
          emit_count <= '0;
          ovf        <= 1'b0;
          seen       <= '0;
        end
        default: ;
      endcase
    end
  end

  // offset and range, offset clamped into 0..range
  assign lo  = fmin[f_reg];
  assign hi  = fmax[f_reg];
  assign dx  = {x_rd[15], x_rd} - {lo[15], lo};
  assign rng = {hi[15], hi} - {lo[15], lo};

  always_comb begin
    if (dx < 0) begin
      dc = '0;
    end else if (dx > rng) begin
      dc = rng;
    end else begin
      dc = dx;
    end
  end

  always_ff @(posedge clk) begin
    if (do_fetch) begin
      f_reg   <= feat;
      rec_reg <= rec;
    end
    if (do_range) begin
      d_reg <= dc[DIV_W-1:0];
      r_reg <= rng[DIV_W-1:0];
      flat  <= !seen[f_reg] || (rng <= 0);
    end
  end

  // quotient to Q1.15, top value saturates, flat or unseen feature gives zero
  always_comb begin
    if (flat) begin
      scaled_calc = '0;
    end else if (div_quo[Q_W-1]) begin
      scaled_calc = 16'sh7FFF;
    end else begin
      scaled_calc = {~div_quo[15], div_quo[14:0]};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit || do_empty) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      scaled_r <= scaled_calc;
      class_r  <= cls_rd;
      feat_r   <= 4'(f_reg);
      rec_r    <= 12'(rec_reg);
      last_r   <= ((emit_count + CNT_W'(1)) == load_count);
      status_r <= ovf ? ST_OVF : ST_OK;
    end else if (do_empty) begin
      scaled_r <= '0;
      class_r  <= '0;
      feat_r   <= '0;
      rec_r    <= '0;
      last_r   <= 1'b0;
      status_r <= ST_EMPTY;
    end
  end

  assign result.valid         = out_valid;
  assign result.scaled        = scaled_r;
  assign result.class_id_out  = class_r;
  assign result.feature_index = feat_r;
  assign result.record_index  = rec_r;
  assign result.last          = last_r;
  assign result.status        = status_r;

  // status back to the sequencer
  assign stat.div_last   = div_last;
  assign stat.load_full  = (load_count == CNT_W'(MAX_SAMPLES));
  assign stat.emit_empty = (emit_count >= load_count);
  assign stat.out_busy   = out_valid && !result.ready;

endmodule

`default_nettype wire

>>> src/min_max_feature_normalizer.sv
`default_nettype none

// channel   dir  payload                                              handshake
// cmd       in   kind, sample, class_id                               valid/ready
// result    out  scaled, class_id_out, feature_index, record_index,   valid/ready
//                last, status
// cfg       in   num_features                                         valid/ready
//
// load: divider start, 13 position steps, sample write; a full set sets the overflow flag.
// emit: divider start, 13 position steps, fetch, range, 17 scale steps in the shared
// restoring divider, output; an empty set gives an empty result; unused kinds are ignored.
// reset clears counters, overflow flag and feature valid bits; sample and class memories
// are not cleared. one result register: a new result waits in its last step until the
// previous one is taken. configuration is taken every cycle.

module min_max_feature_normalizer import mmfn_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  mmfn_cmd_if.sink      cmd,
  mmfn_result_if.source result,
  mmfn_cfg_if.sink      cfg
);

  logic [NF_W-1:0] num_features;
  logic [NF_W-1:0] nf_eff;
  ctl_t            ctl;
  stat_t           stat;
  logic            idle;
  logic            accept;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_features <= NF_W'(1);
    end else if (cfg.valid) begin
      num_features <= cfg.num_features;
    end
  end

  // features per record limited to 1..MAX_FEATURES
  always_comb begin
    if (num_features == '0) begin
      nf_eff = NF_W'(1);
    end else if (num_features > NF_W'(MAX_FEATURES)) begin
      nf_eff = NF_W'(MAX_FEATURES);
    end else begin
      nf_eff = num_features;
    end
  end

  // requests are taken at the idle step only
  assign cmd.ready = idle;
  assign accept    = cmd.valid && idle;

  mmfn_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_kind  (cmd.kind),
    .stat      (stat),
    .ctl       (ctl),
    .idle      (idle)
  );

  mmfn_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .accept       (accept),
    .cmd_sample   (cmd.sample),
    .cmd_class_id (cmd.class_id),
    .nf           (nf_eff),
    .stat         (stat),
    .result       (result)
  );

  // a real request leaves the idle step
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.kind != K_UNUSED) |=> !idle)
    else $error("sequencer stayed idle after a request");

  // the output step holds back only on a full result register
  a_fire_hold: assert property (@(posedge clk) disable iff (rst)
    !ctl.fire |-> stat.out_busy)
    else $error("operation held without a busy result register");

  // an empty answer carries zero fields
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == ST_EMPTY) |->
      (result.scaled == 16'sd0) && !result.last && (result.record_index == 12'd0))
    else $error("empty result with nonzero fields");

  // a new result only comes from a running program
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(!idle))
    else $error("result appeared while idle");

endmodule

`default_nettype wire

>>> tb/tb_min_max_feature_normalizer.sv
module tb_min_max_feature_normalizer;
  import mmfn_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int RANDOM_ITEMS  = 580;
  localparam int MAX_REPORTS   = 10;

  // one normalized sample as the block returns it
  typedef struct packed {
    logic signed [15:0] scaled;
    logic [5:0]         class_id_out;
    logic [3:0]         feature_index;
    logic [11:0]        record_index;
    logic               last;
    logic [1:0]         status;
  } norm_result_t;

  logic clk;
  logic rst;

  mmfn_cmd_if    cmd ();
  mmfn_result_if result ();
  mmfn_cfg_if    cfg ();

  min_max_feature_normalizer dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .result (result),
    .cfg    (cfg)
  );

  // mirror of the data set held by the block
  logic [15:0]               stored_samples [MAX_SAMPLES];
  logic [5:0]                stored_classes [MAX_SAMPLES];
  logic signed [15:0]        feat_lo [MAX_FEATURES];
  logic signed [15:0]        feat_hi [MAX_FEATURES];
  logic [MAX_FEATURES-1:0]   feat_loaded = '0;
  int unsigned               load_total = 0;
  int unsigned               emit_total = 0;
  logic                      overflowed = 1'b0;
  logic [NF_W-1:0]           num_features_reg = 5'd1;

  norm_result_t pending_results [$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned requests_sent = 0;
  int unsigned random_items = 0;
  int unsigned burst_left = 0;
  int unsigned hold_left = 0;
  logic [31:0] nf_values_seen = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("run stopped after %0d cycles with %0d results outstanding",
             cycle_count, pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // random payload fields
  function automatic logic signed [15:0] any_sample();
    return 16'($urandom());
  endfunction

  function automatic logic [5:0] any_class();
    return 6'($urandom());
  endfunction

  // register value as the block applies it
  function automatic int unsigned active_features();
    if (num_features_reg == 0) return 1;
    if (num_features_reg > MAX_FEATURES) return MAX_FEATURES;
    return 32'(num_features_reg);
  endfunction

  // 2*(x-min)/(max-min)-1 in q1.15, range clamped, top saturated
  function automatic logic signed [15:0] rescale_sample(logic signed [15:0] x,
                                                        int unsigned f);
    int     lo, hi, d, r;
    longint q;
    if (!feat_loaded[f]) return '0;
    lo = int'(feat_lo[f]);
    hi = int'(feat_hi[f]);
    if (hi <= lo) return '0;
    r = hi - lo;
    d = int'(x) - lo;
    if (d < 0) d = 0;
    if (d > r) d = r;
    q = (longint'(d) * 65536) / r - 32768;
    if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  // update the mirror for one accepted request, queue its result if any
  function automatic void predict_request(logic [1:0] kind, logic signed [15:0] x,
                                          logic [5:0] cls);
    int unsigned  nf, f, rec;
    norm_result_t r;
    nf = active_features();
    case (kind)
      K_LOAD: begin
        if (load_total >= MAX_SAMPLES) begin
          overflowed = 1'b1;
        end else begin
          f = load_total % nf;
          rec = load_total / nf;
          stored_samples[load_total] = x;
          if (f == 0) stored_classes[rec] = cls;
          if (!feat_loaded[f]) begin
            feat_lo[f] = x;
            feat_hi[f] = x;
            feat_loaded[f] = 1'b1;
          end else begin
            if (x < feat_lo[f]) feat_lo[f] = x;
            if (x > feat_hi[f]) feat_hi[f] = x;
          end
          load_total++;
        end
      end
      K_EMIT: begin
        r = '0;
        if (emit_total >= load_total) begin
          r.status = ST_EMPTY;
        end else begin
          f = emit_total % nf;
          rec = emit_total / nf;
          r.scaled = rescale_sample($signed(stored_samples[emit_total]), f);
          r.class_id_out = stored_classes[rec];
          r.feature_index = f[3:0];
          r.record_index = rec[11:0];
          r.last = (emit_total + 1 == load_total);
          r.status = overflowed ? ST_OVF : ST_OK;
          emit_total++;
        end
        pending_results = {pending_results, r};
      end
      K_CLEAR: begin
        load_total = 0;
        emit_total = 0;
        overflowed = 1'b0;
        feat_loaded = '0;
      end
      default: ;
    endcase
  endfunction

  // one request on the command channel, sender sometimes idles between bursts
  task automatic send_request(input logic [1:0] kind, input logic signed [15:0] x,
                              input logic [5:0] cls);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        cmd.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    cmd.valid <= 1'b1;
    cmd.kind <= kind;
    cmd.sample <= x;
    cmd.class_id <= cls;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    predict_request(kind, x, cls);
    requests_sent++;
  endtask

  // drop valid and let every result and any load in flight finish
  task automatic wait_idle();
    @(negedge clk);
    cmd.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_num_features(input logic [4:0] value);
    wait_idle();
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.num_features <= value;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    num_features_reg = value;
    nf_values_seen[value] = 1'b1;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample(int unsigned mode,
                                                     logic signed [15:0] centre);
    logic [15:0] v;
    case (mode)
      0: v = 16'($urandom());
      1: v = centre + 16'($urandom_range(0, 7));
      2: begin
        case ($urandom_range(0, 2))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          default: v = 16'($urandom());
        endcase
      end
      default: v = centre;
    endcase
    return v;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("mismatch in %s of result %0d: expected %0d, got %0d",
                 name, results_checked, want, got);
    end
  endtask

  // result checker
  initial begin : result_monitor
    norm_result_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && result.valid === 1'b1 && result.ready === 1'b1) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result %0d arrived with no emit request waiting", results_checked);
        end else begin
          want = pending_results.pop_front();
          check_field("scaled", want.scaled, result.scaled);
          check_field("class_id_out", want.class_id_out, result.class_id_out);
          check_field("feature_index", want.feature_index, result.feature_index);
          check_field("record_index", want.record_index, result.record_index);
          check_field("last", want.last, result.last);
          check_field("status", want.status, result.status);
        end
      end
    end
  end

  // result ready: rotating stall patterns, or a long hold when asked
  initial begin : result_ready_drive
    logic [15:0] pattern;
    int unsigned step;
    pattern = '1;
    step = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        if (step == 0) begin
          case ($urandom_range(0, 3))
            0: pattern = '1;
            1: pattern = 16'($urandom()) | 16'h0001;
            2: pattern = 16'h5555 << $urandom_range(0, 1);
            default: pattern = ~(16'h0001 << $urandom_range(0, 15));
          endcase
        end
        result.ready <= pattern[step % 16];
        step = (step + 1) % 48;
      end
    end
  end

  // an emit on an empty set, an unused request kind and a clear
  task automatic test_empty_and_ignored();
    send_request(K_EMIT, 16'h7fff, 6'd63);
    send_request(K_UNUSED, 16'h8000, 6'd0);
    send_request(K_CLEAR, 16'hffff, 6'd63);
  endtask

  // full-range feature, flat feature and a narrow feature
  task automatic test_extreme_samples();
    int unsigned i;
    write_num_features(5'd3);
    send_request(K_CLEAR, '0, '0);
    send_request(K_LOAD, -16'sd32768, 6'd63);
    send_request(K_LOAD, 16'sd5, 6'd21);
    send_request(K_LOAD, 16'sd7, 6'd42);
    send_request(K_LOAD, 16'sd32767, 6'd0);
    send_request(K_LOAD, 16'sd5, 6'd0);
    send_request(K_LOAD, -16'sd1, 6'd0);
    for (i = 0; i < 7; i++) send_request(K_EMIT, '0, '0);
  endtask

  // widen records mid-set: samples land outside their new feature range,
  // and a feature with no samples yet
  task automatic test_record_width_change();
    int unsigned i;
    write_num_features(5'd2);
    send_request(K_CLEAR, '0, '0);
    send_request(K_LOAD, 16'sd100, 6'd11);
    send_request(K_LOAD, -16'sd50, 6'd0);
    send_request(K_LOAD, 16'sd200, 6'd22);
    send_request(K_LOAD, 16'sd50, 6'd0);
    send_request(K_LOAD, 16'sd150, 6'd33);
    send_request(K_LOAD, 16'sd0, 6'd0);
    write_num_features(5'd3);
    for (i = 0; i < 5; i++) send_request(K_EMIT, '0, '0);
  endtask

  task automatic run_register_setting(input logic [4:0] value);
    int unsigned i, n;
    write_num_features(value);
    send_request(K_CLEAR, any_sample(), any_class());
    n = active_features() + 1;
    for (i = 0; i < n; i++) send_request(K_LOAD, any_sample(), any_class());
    for (i = 0; i <= n; i++) send_request(K_EMIT, any_sample(), any_class());
  endtask

  // zero and values above the feature limit, plus both legal ends
  task automatic test_register_extremes();
    run_register_setting(5'd0);
    run_register_setting(5'd31);
    run_register_setting(5'd17);
    run_register_setting(5'd16);
    run_register_setting(5'd1);
  endtask

  // receiver holds off while emits keep coming, so the block stalls its input
  task automatic test_output_backpressure();
    int unsigned i;
    write_num_features(5'd4);
    send_request(K_CLEAR, '0, '0);
    for (i = 0; i < 12; i++) send_request(K_LOAD, any_sample(), any_class());
    hold_left = 300;
    for (i = 0; i < 13; i++) send_request(K_EMIT, any_sample(), any_class());
  endtask

  // one data set: clear, loads with emits mixed in, then drain
  task automatic run_random_phase();
    logic [4:0]         reg_val;
    logic signed [15:0] centre;
    int unsigned        nf, n_loads, mode, i;
    if ($urandom_range(0, 7) == 0)
      reg_val = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
    else
      reg_val = 5'($urandom_range(1, 16));
    write_num_features(reg_val);
    nf = active_features();
    send_request(K_CLEAR, any_sample(), any_class());
    random_items++;
    n_loads = nf * $urandom_range(1, 6);
    if ($urandom_range(0, 3) == 0) n_loads -= $urandom_range(0, nf - 1);
    mode = $urandom_range(0, 3);
    centre = any_sample();
    for (i = 0; i < n_loads; i++) begin
      // occasional noise, a broken set, or an early emit
      case ($urandom_range(0, 39))
        0: send_request(K_UNUSED, any_sample(), any_class());
        1: begin
          send_request(K_CLEAR, any_sample(), any_class());
          random_items++;
        end
        2, 3, 4, 5, 6, 7: begin
          send_request(K_EMIT, any_sample(), any_class());
          random_items++;
        end
        default: ;
      endcase
      send_request(K_LOAD,
                   ($urandom_range(0, 9) == 0) ? pick_sample(0, centre)
                                                : pick_sample(mode, centre),
                   any_class());
      random_items++;
    end
    while (emit_total < load_total) begin
      send_request(K_EMIT, any_sample(), any_class());
      random_items++;
    end
    if ($urandom_range(0, 1) == 1) begin
      send_request(K_EMIT, any_sample(), any_class());
      random_items++;
    end
  endtask

  task automatic test_random_data_sets();
    while (random_items < RANDOM_ITEMS) run_random_phase();
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.kind = K_LOAD;
    cmd.sample = '0;
    cmd.class_id = '0;
    cfg.valid = 1'b0;
    cfg.num_features = 5'd1;
    result.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_ignored();
    test_extreme_samples();
    test_record_width_change();
    test_register_extremes();
    test_output_backpressure();
    test_random_data_sets();

    wait_idle();
    $display("run covered %0d requests and %0d checked results over %0d register values,",
             requests_sent, results_checked, $countones(nf_values_seen));
    $display("with flat and full-range features, a long output stall, and %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
